[rtl/actd_pkg.sv]
// ============================================================================
// actd_pkg
// Shared widths, register indexes, reset values and phase codes for the
// accelerometer clap transient detector.
// ============================================================================
`default_nettype none

package actd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int MAG_BITS    = 34;
    localparam int MS_BITS     = 16;

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int SQ_BITS   = 2 * SAMPLE_BITS + 1;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int CMP_BITS  = (SUM_BITS > MAG_BITS) ? SUM_BITS : MAG_BITS;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = MAG_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RISE_THR = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FALL_THR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_THR  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RISE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_OUT  = 3'd4;

    localparam logic [MAG_BITS-1:0] MAG_MAX        = '1;
    localparam logic [MAG_BITS-1:0] RST_RISE_THR   = 34'd32883343;
    localparam logic [MAG_BITS-1:0] RST_FALL_THR   = 34'd32883343;
    localparam logic [MAG_BITS-1:0] RST_OUT_THR    = 34'd10737418;
    localparam logic [MS_BITS-1:0]  RST_MAX_RISE   = 16'd40;
    localparam logic [MS_BITS-1:0]  RST_MAX_OUT    = 16'd120;

    localparam logic [1:0] PHC_RISE = 2'd0;
    localparam logic [1:0] PHC_FALL = 2'd1;
    localparam logic [1:0] PHC_OUT  = 2'd2;

    typedef enum logic [2:0] {
        PH_RISE = 3'b001,
        PH_FALL = 3'b010,
        PH_OUT  = 3'b100
    } t_phase;

endpackage

`default_nettype wire

[rtl/accel_clap_transient_detector.sv]
// ============================================================================
// accel_clap_transient_detector
// Clap detector on the squared sample-to-sample change of a three-axis
// accelerometer stream, with rise, fall and rebound phases.
// ============================================================================
// Input channel: i_in_valid / o_in_ready carry one word per sample (three
// signed axes and a millisecond timestamp). Output channel: o_out_valid /
// i_out_ready return one word per sample: clap flag, phase after the sample
// and the squared change magnitude.
// Configuration channel: i_cfg_valid / o_cfg_ready with a register index and
// data; always ready. Write only while the block is idle.
// Five register stages lie between input accept and output valid:
// difference, square, sum, threshold compare, phase update. One word is
// accepted every cycle while the output is not stalled.
// Each stage advances when the next one is empty or moving, so bubbles close
// up and a stalled receiver holds the output register while the upstream
// stages keep filling; the input stalls only once all five stages are full.
// Reset clears the pipeline, the phase (wait rise), the phase start time and
// the primed flag, and loads the default thresholds and timeouts. The first
// sample after reset only primes the previous sample and reports a zero
// magnitude.
// ============================================================================
`default_nettype none

module accel_clap_transient_detector (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_in_valid,
    output logic                                     o_in_ready,
    input  wire  signed [actd_pkg::SAMPLE_BITS-1:0]  i_accel_x,
    input  wire  signed [actd_pkg::SAMPLE_BITS-1:0]  i_accel_y,
    input  wire  signed [actd_pkg::SAMPLE_BITS-1:0]  i_accel_z,
    input  wire         [actd_pkg::TIME_BITS-1:0]    i_now_ms,
    output logic                                     o_out_valid,
    input  wire                                      i_out_ready,
    output logic                                     o_clap_detected,
    output logic        [1:0]                        o_detector_phase,
    output logic        [actd_pkg::MAG_BITS-1:0]     o_delta_mag_sq,
    input  wire                                      i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire         [actd_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire         [actd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int SB  = actd_pkg::SAMPLE_BITS;
    localparam int TB  = actd_pkg::TIME_BITS;
    localparam int MB  = actd_pkg::MAG_BITS;
    localparam int DB  = actd_pkg::DIFF_BITS;
    localparam int PB  = actd_pkg::PROD_BITS;
    localparam int QB  = actd_pkg::SQ_BITS;
    localparam int UB  = actd_pkg::SUM_BITS;
    localparam int CB  = actd_pkg::CMP_BITS;
    localparam int MSB = actd_pkg::MS_BITS;

    // configuration
    logic [MB-1:0]  r_rise_thr, r_fall_thr, r_out_thr;
    logic [MSB-1:0] r_max_rise, r_max_out;

    // detector state
    logic signed [SB-1:0] r_prev_x, r_prev_y, r_prev_z;
    logic                 r_primed;
    actd_pkg::t_phase     r_phase, n_phase;
    logic [TB-1:0]        r_start, n_start;
    logic                 n_clap;

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    // stage 1: differences
    logic signed [DB-1:0] r1_dx, r1_dy, r1_dz;
    logic [TB-1:0]        r1_now;
    logic                 r1_first;
    // stage 2: squares
    logic [QB-1:0]        r2_sqx, r2_sqy, r2_sqz;
    logic [TB-1:0]        r2_now;
    logic                 r2_first;
    // stage 3: magnitude
    logic [UB-1:0]        r3_mag;
    logic [TB-1:0]        r3_now;
    logic                 r3_first;
    // stage 4: compares
    logic                 r4_gt_rise, r4_lt_fall, r4_gt_out;
    logic [MB-1:0]        r4_mag;
    logic [TB-1:0]        r4_now;
    logic                 r4_first;
    // stage 5: result
    logic                 r5_clap;
    logic [1:0]           r5_phase;
    logic [MB-1:0]        r5_mag;

    logic signed [DB-1:0] n_dx, n_dy, n_dz;
    logic signed [PB-1:0] prod_x, prod_y, prod_z;
    logic [UB-1:0]        n_mag;
    logic                 mag_sat;
    logic [TB-1:0]        elapsed;
    logic [TB-1:0]        max_rise_ext, max_out_ext;

    assign en5 = !r_v5 || i_out_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_ready  = en1;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_thr <= actd_pkg::RST_RISE_THR;
            r_fall_thr <= actd_pkg::RST_FALL_THR;
            r_out_thr  <= actd_pkg::RST_OUT_THR;
            r_max_rise <= actd_pkg::RST_MAX_RISE;
            r_max_out  <= actd_pkg::RST_MAX_OUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                actd_pkg::CFG_RISE_THR: r_rise_thr <= i_cfg_data[MB-1:0];
                actd_pkg::CFG_FALL_THR: r_fall_thr <= i_cfg_data[MB-1:0];
                actd_pkg::CFG_OUT_THR:  r_out_thr  <= i_cfg_data[MB-1:0];
                actd_pkg::CFG_MAX_RISE: r_max_rise <= i_cfg_data[MSB-1:0];
                actd_pkg::CFG_MAX_OUT:  r_max_out  <= i_cfg_data[MSB-1:0];
                default: ;
            endcase
        end
    end

    assign n_dx = {i_accel_x[SB-1], i_accel_x} - {r_prev_x[SB-1], r_prev_x};
    assign n_dy = {i_accel_y[SB-1], i_accel_y} - {r_prev_y[SB-1], r_prev_y};
    assign n_dz = {i_accel_z[SB-1], i_accel_z} - {r_prev_z[SB-1], r_prev_z};

    assign prod_x = r1_dx * r1_dx;
    assign prod_y = r1_dy * r1_dy;
    assign prod_z = r1_dz * r1_dz;

    assign n_mag = UB'(r2_sqx) + UB'(r2_sqy) + UB'(r2_sqz);
    assign mag_sat = r3_mag > UB'(actd_pkg::MAG_MAX);

    assign elapsed      = r4_now - r_start;
    assign max_rise_ext = TB'(r_max_rise);
    assign max_out_ext  = TB'(r_max_out);

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_clap  = 1'b0;
        if (!r4_first) begin
            unique case (r_phase)
                actd_pkg::PH_FALL: begin
                    if (r4_lt_fall) begin
                        n_phase = actd_pkg::PH_OUT;
                        n_start = r4_now;
                    end else if (elapsed > max_rise_ext) begin
                        n_phase = actd_pkg::PH_RISE;
                    end
                end
                actd_pkg::PH_OUT: begin
                    if (r4_gt_out) begin
                        n_clap  = 1'b1;
                        n_phase = actd_pkg::PH_RISE;
                    end else if (elapsed > max_out_ext) begin
                        n_phase = actd_pkg::PH_RISE;
                    end
                end
                default: begin
                    if (r4_gt_rise) begin
                        n_phase = actd_pkg::PH_FALL;
                        n_start = r4_now;
                    end else begin
                        n_phase = actd_pkg::PH_RISE;
                    end
                end
            endcase
        end
    end

    // valid chain and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_primed <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_prev_z <= '0;
            r_phase  <= actd_pkg::PH_RISE;
            r_start  <= '0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en1 && i_in_valid) begin
                r_primed <= 1'b1;
                r_prev_x <= i_accel_x;
                r_prev_y <= i_accel_y;
                r_prev_z <= i_accel_z;
            end
            if (en5 && r_v4) begin
                r_phase <= n_phase;
                r_start <= n_start;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r1_dx    <= n_dx;
            r1_dy    <= n_dy;
            r1_dz    <= n_dz;
            r1_now   <= i_now_ms;
            r1_first <= !r_primed;
        end
        if (en2 && r_v1) begin
            r2_sqx   <= prod_x[QB-1:0];
            r2_sqy   <= prod_y[QB-1:0];
            r2_sqz   <= prod_z[QB-1:0];
            r2_now   <= r1_now;
            r2_first <= r1_first;
        end
        if (en3 && r_v2) begin
            r3_mag   <= r2_first ? '0 : n_mag;
            r3_now   <= r2_now;
            r3_first <= r2_first;
        end
        if (en4 && r_v3) begin
            r4_gt_rise <= CB'(r3_mag) > CB'(r_rise_thr);
            r4_lt_fall <= CB'(r3_mag) < CB'(r_fall_thr);
            r4_gt_out  <= CB'(r3_mag) > CB'(r_out_thr);
            r4_mag     <= mag_sat ? actd_pkg::MAG_MAX : MB'(r3_mag);
            r4_now     <= r3_now;
            r4_first   <= r3_first;
        end
        if (en5 && r_v4) begin
            r5_clap <= n_clap;
            r5_mag  <= r4_mag;
            unique case (n_phase)
                actd_pkg::PH_FALL: r5_phase <= actd_pkg::PHC_FALL;
                actd_pkg::PH_OUT:  r5_phase <= actd_pkg::PHC_OUT;
                default:           r5_phase <= actd_pkg::PHC_RISE;
            endcase
        end
    end

    assign o_out_valid      = r_v5;
    assign o_clap_detected  = r5_clap;
    assign o_detector_phase = r5_phase;
    assign o_delta_mag_sq   = r5_mag;

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("detector phase lost its one-hot code");

    a_clap_ends_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clap_detected |-> o_detector_phase == actd_pkg::PHC_RISE)
        else $error("clap reported outside wait-rise phase");

    a_no_skip_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == actd_pkg::PH_RISE |=> r_phase != actd_pkg::PH_OUT)
        else $error("phase jumped from wait rise to wait rebound");

    a_prime_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en5 && r_v4 && r4_first |=> !r5_clap && r5_mag == '0)
        else $error("priming sample produced a nonzero result");

endmodule

`default_nettype wire
